@@ hw/rtl/bba_pkg.sv @@
package bba_pkg;

  // default bitmap depth in 64-bit words
  localparam int unsigned BITMAP_WORDS_DEF = 1024;

  localparam int unsigned WORD_BITS = 64;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_DATA_START = 2'd0;
  localparam logic [1:0] CFG_TOTAL      = 2'd1;
  localparam logic [1:0] CFG_INIT_FREE  = 2'd2;
  localparam logic [1:0] CFG_WORDS_USED = 2'd3;

  typedef struct packed {
    logic        command;
    logic [9:0]  word_index;
    logic [63:0] word_data;
  } bba_in_t;

  typedef struct packed {
    logic [31:0] block_number;
    logic [1:0]  status;
    logic [31:0] free_left;
  } bba_out_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [31:0] data_start_block;
    logic [31:0] total_block_count;
    logic [31:0] initial_free_count;
    logic [10:0] words_in_use;
  } bba_cfg_t;

endpackage

@@ hw/rtl/bba_bitmap_ram.sv @@
module bba_bitmap_ram #(
  parameter int unsigned BITMAP_WORDS = bba_pkg::BITMAP_WORDS_DEF,
  parameter int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [BITMAP_WORDS];
  logic [63:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bba_engine.sv @@
module bba_engine #(
  parameter int unsigned BITMAP_WORDS = bba_pkg::BITMAP_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::bba_cfg_t cfg_i,
  input  logic              start_i,
  input  bba_pkg::bba_in_t  item_i,
  output logic              ready_o,
  output logic              done_o,
  input  logic              take_i,
  output bba_pkg::bba_out_t res_o
);

  localparam int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned CW = $clog2(BITMAP_WORDS + 1);
  localparam logic [63:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_COMPARE,
    S_DONE
  } state_e;

  state_e      state_q;
  logic [CW-1:0] ptr_q;
  logic [CW-1:0] limit_q;
  logic [63:0] word_q;
  logic [5:0]  bit_q;
  logic [32:0] cand_q;
  logic [31:0] num_q;
  logic [1:0]  st_q;
  logic [31:0] made_q;

  logic [31:0]   free_cnt;
  logic [CW-1:0] limit;
  logic          idx_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;
  logic [5:0]    enc_bit;
  logic          beyond;

  // lowest clear bit by halving, six steps
  function automatic logic [5:0] lowest_zero(input logic [63:0] w);
    logic [63:0] v;
    logic [5:0]  b;
    v = w;
    b = '0;
    if (&v[31:0]) begin
      b[5] = 1'b1;
      v = v >> 32;
    end
    if (&v[15:0]) begin
      b[4] = 1'b1;
      v = v >> 16;
    end
    if (&v[7:0]) begin
      b[3] = 1'b1;
      v = v >> 8;
    end
    if (&v[3:0]) begin
      b[2] = 1'b1;
      v = v >> 4;
    end
    if (&v[1:0]) begin
      b[1] = 1'b1;
      v = v >> 2;
    end
    if (v[0]) begin
      b[0] = 1'b1;
    end
    return b;
  endfunction

  // free count, saturated at zero
  assign free_cnt = (cfg_i.initial_free_count > made_q) ?
                    (cfg_i.initial_free_count - made_q) : 32'd0;

  // search limit clipped to the bitmap depth
  assign limit = (32'(cfg_i.words_in_use) > 32'(BITMAP_WORDS)) ?
                 CW'(BITMAP_WORDS) : CW'(cfg_i.words_in_use);

  assign idx_ok  = 32'(item_i.word_index) < 32'(BITMAP_WORDS);
  assign enc_bit = lowest_zero(ram_rdata);
  assign beyond  = cand_q >= {1'b0, cfg_i.total_block_count};

  // memory port control
  assign ram_we = ((state_q == S_IDLE) && start_i && (item_i.command == bba_pkg::CMD_LOAD)
                   && idx_ok) || ((state_q == S_COMPARE) && !beyond);
  assign ram_waddr = (state_q == S_IDLE) ? AW'(item_i.word_index) : ptr_q[AW-1:0];
  assign ram_wdata = (state_q == S_IDLE) ? item_i.word_data :
                     (word_q | (64'd1 << bit_q));

  bba_bitmap_ram #(
    .BITMAP_WORDS(BITMAP_WORDS),
    .AW          (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (state_q == S_READ),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      limit_q <= '0;
      word_q  <= '0;
      bit_q   <= '0;
      cand_q  <= '0;
      num_q   <= '0;
      st_q    <= bba_pkg::ST_OK;
      made_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            num_q <= '0;
            ptr_q <= '0;
            limit_q <= limit;
            if (item_i.command == bba_pkg::CMD_LOAD) begin
              st_q    <= bba_pkg::ST_OK;
              state_q <= S_DONE;
            end else if (free_cnt == 32'd0) begin
              st_q    <= bba_pkg::ST_NO_FREE;
              state_q <= S_DONE;
            end else if (limit == '0) begin
              st_q    <= bba_pkg::ST_FULL;
              state_q <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (ram_rdata != ALL_ONES) begin
            word_q  <= ram_rdata;
            bit_q   <= enc_bit;
            cand_q  <= 33'(cfg_i.data_start_block) + 33'({ptr_q, enc_bit});
            state_q <= S_COMPARE;
          end else if ((ptr_q + CW'(1)) == limit_q) begin
            st_q    <= bba_pkg::ST_FULL;
            state_q <= S_DONE;
          end else begin
            ptr_q   <= ptr_q + CW'(1);
            state_q <= S_READ;
          end
        end
        S_COMPARE: begin
          if (beyond) begin
            st_q <= bba_pkg::ST_BEYOND;
          end else begin
            st_q   <= bba_pkg::ST_OK;
            num_q  <= cand_q[31:0];
            made_q <= made_q + 32'd1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign res_o   = '{block_number: num_q, status: st_q, free_left: free_cnt};

endmodule

@@ hw/rtl/bitmap_block_allocator.sv @@
// First-fit block allocator over a bitmap of 64-bit words held in an on-chip
// memory of BITMAP_WORDS entries. A load item writes one bitmap word and passes
// its result through the engine's done state to the output register. An allocate
// item scans the words in use from word zero with one memory read and compare per
// word, stopping at the first non-full word; a free-count error skips the scan.
// Words must be loaded before an allocation searches them. The result register
// lets the next item be accepted while a result waits. Configuration writes are
// taken at any time; the user must make them only while the block is idle, for a
// defined effect, as the block itself does not enforce this.
module bitmap_block_allocator #(
  parameter int unsigned BITMAP_WORDS = bba_pkg::BITMAP_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bba_pkg::bba_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bba_pkg::bba_out_t out_item_o
);

  bba_pkg::bba_cfg_t  cfg_q;
  bba_pkg::bba_out_t  out_q;
  bba_pkg::bba_out_t  res;
  logic               out_valid_q;
  logic               eng_ready;
  logic               eng_done;
  logic               take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bba_pkg::CFG_DATA_START: cfg_q.data_start_block   <= cfg_data_i;
        bba_pkg::CFG_TOTAL:      cfg_q.total_block_count  <= cfg_data_i;
        bba_pkg::CFG_INIT_FREE:  cfg_q.initial_free_count <= cfg_data_i;
        bba_pkg::CFG_WORDS_USED: cfg_q.words_in_use       <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // result slot is free when empty or being drained
  assign take = !out_valid_q || out_ready_i;

  bba_engine #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .start_i(in_valid_i && eng_ready),
    .item_i (in_item_i),
    .ready_o(eng_ready),
    .done_o (eng_done),
    .take_i (take),
    .res_o  (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_done && take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done && take) begin
      out_q <= res;
    end
  end

  assign in_ready_o  = eng_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ tb/bba_result_checker.sv @@
`timescale 1ns / 1ps

module bba_result_checker #(
  parameter int unsigned WORDS = bba_pkg::BITMAP_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bba_pkg::bba_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bba_pkg::bba_out_t out_item_i,
  output int unsigned       failures_o,
  output int unsigned       pending_o,
  output logic              scan_safe_o,
  output logic [9:0]        gap_word_o,
  output logic [3:0][31:0]  status_hits_o
);
  import bba_pkg::*;

  // shadow of the block's registers and state
  bba_cfg_t    cfg;
  logic [63:0] bitmap_words [WORDS];
  bit          word_loaded [WORDS];
  logic [31:0] allocs_done;
  bba_out_t    awaited_results [$];

  function automatic logic [31:0] free_blocks_left();
    if (cfg.initial_free_count > allocs_done) begin
      return cfg.initial_free_count - allocs_done;
    end
    return '0;
  endfunction

  // oversized word counts are clamped to the bitmap depth
  function automatic int unsigned words_searched();
    if (cfg.words_in_use > WORDS) begin
      return WORDS;
    end
    return cfg.words_in_use;
  endfunction

  // apply one command to the shadow state and work out its result item
  task automatic run_command(input bba_in_t cmd, output bba_out_t res);
    int unsigned limit;
    int unsigned i;
    int unsigned w;
    int unsigned bit_pos;
    logic        found;
    logic [63:0] cand;
    res = '0;
    res.status = ST_OK;
    if (cmd.command == CMD_LOAD) begin
      if (cmd.word_index < WORDS) begin
        bitmap_words[cmd.word_index] = cmd.word_data;
        word_loaded[cmd.word_index] = 1'b1;
      end
    end else if (free_blocks_left() == 0) begin
      res.status = ST_NO_FREE;
    end else begin
      limit = words_searched();
      found = 1'b0;
      w = 0;
      for (i = 0; i < limit; i++) begin
        if (bitmap_words[i] != '1) begin
          w = i;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        res.status = ST_FULL;
      end else begin
        bit_pos = 0;
        while (bit_pos < WORD_BITS - 1 && bitmap_words[w][bit_pos]) begin
          bit_pos++;
        end
        // formed wide so that a carry past 32 bits lands beyond the disk
        cand = 64'(cfg.data_start_block) + 64'(w) * WORD_BITS + 64'(bit_pos);
        if (cand >= 64'(cfg.total_block_count)) begin
          res.status = ST_BEYOND;
        end else begin
          bitmap_words[w][bit_pos] = 1'b1;
          allocs_done++;
          res.block_number = cand[31:0];
        end
      end
    end
    res.free_left = free_blocks_left();
  endtask

  // would an allocate now read only loaded words, and if not, which word is missing
  task automatic update_scan_safety();
    int unsigned limit;
    int unsigned i;
    scan_safe_o = 1'b1;
    gap_word_o = '0;
    if (free_blocks_left() != 0) begin
      limit = words_searched();
      for (i = 0; i < limit; i++) begin
        if (!word_loaded[i]) begin
          scan_safe_o = 1'b0;
          gap_word_o = i[9:0];
          break;
        end
        if (bitmap_words[i] != '1) begin
          break;
        end
      end
    end
  endtask

  // watch all three channels, predict on input items, compare on result items
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bba_out_t predicted;
    bba_out_t oldest;
    logic     touched;
    int unsigned i;
    if (!rst_ni) begin
      cfg = '0;
      allocs_done = '0;
      for (i = 0; i < WORDS; i++) begin
        bitmap_words[i] = '0;
        word_loaded[i] = 1'b0;
      end
      awaited_results.delete();
      failures_o = 0;
      pending_o = 0;
      status_hits_o = '0;
      scan_safe_o = 1'b1;
      gap_word_o = '0;
    end else begin
      touched = 1'b0;
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DATA_START: cfg.data_start_block = cfg_data_i;
          CFG_TOTAL:      cfg.total_block_count = cfg_data_i;
          CFG_INIT_FREE:  cfg.initial_free_count = cfg_data_i;
          CFG_WORDS_USED: cfg.words_in_use = cfg_data_i[10:0];
          default: ;
        endcase
        touched = 1'b1;
      end
      // results first: an item accepted this edge cannot have its result yet
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result item with nothing awaited: block_number %0h status %0d free_left %0h",
                 out_item_i.block_number, out_item_i.status, out_item_i.free_left);
          failures_o++;
        end else begin
          oldest = awaited_results.pop_front();
          status_hits_o[oldest.status]++;
          if (out_item_i.block_number !== oldest.block_number) begin
            $error("block_number: expected %0h, got %0h", oldest.block_number,
                   out_item_i.block_number);
            failures_o++;
          end
          if (out_item_i.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_item_i.status);
            failures_o++;
          end
          if (out_item_i.free_left !== oldest.free_left) begin
            $error("free_left: expected %0h, got %0h", oldest.free_left, out_item_i.free_left);
            failures_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_command(in_item_i, predicted);
        awaited_results.push_back(predicted);
        touched = 1'b1;
      end
      if (touched) begin
        update_scan_safety();
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

@@ tb/bitmap_block_allocator_test.sv @@
`timescale 1ns / 1ps

module bitmap_block_allocator_test;
  import bba_pkg::*;

  // longest item is a scan of every word, plus receiver stalls
  localparam int unsigned WATCHDOG_LIMIT    = 20000;
  localparam int unsigned RANDOM_SETTINGS   = 10;
  localparam int unsigned ITEMS_PER_SETTING = 73;
  localparam int unsigned SETTLE_CYCLES     = 8;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_DATA_START;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  bba_in_t     in_item_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  bba_out_t    out_item_o;

  int unsigned      failures;
  int unsigned      pending;
  logic             scan_safe;
  logic [9:0]       gap_word;
  logic [3:0][31:0] status_hits;

  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles   = 0;

  bitmap_block_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  bba_result_checker result_watch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_i    (out_item_o),
    .failures_o    (failures),
    .pending_o     (pending),
    .scan_safe_o   (scan_safe),
    .gap_word_o    (gap_word),
    .status_hits_o (status_hits)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL bitmap_block_allocator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input item, with random sender gaps ahead of it
  task automatic send_item(input bba_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // bitmap word contents, weighted towards full and nearly full words
  function automatic logic [63:0] random_word();
    case ($urandom_range(9))
      0, 1, 2: return '1;
      3, 4, 5: return {$urandom, $urandom};
      6:       return ~(64'd1 << $urandom_range(WORD_BITS - 1));
      7:       return '0;
      8:       return {$urandom, $urandom} | 64'hFFFF_FFFF;
      default: return ~(64'd1 << (WORD_BITS - 1));
    endcase
  endfunction

  task automatic load_word(input logic [9:0] idx, input logic [63:0] data);
    bba_in_t item;
    item.command = CMD_LOAD;
    item.word_index = idx;
    item.word_data = data;
    send_item(item);
  endtask

  // fill any unloaded word on the search path before asking for a block
  task automatic allocate_block();
    bba_in_t item;
    while (!scan_safe) begin
      load_word(gap_word, random_word());
    end
    item.command = CMD_ALLOC;
    item.word_index = 10'($urandom);
    item.word_data = {$urandom, $urandom};
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  // one register write, valid left high for the next one
  task automatic cfg_put(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // registers are only touched once the block has gone quiet
  task automatic apply_settings(input logic [31:0] start, input logic [31:0] total,
                                input logic [31:0] free_count, input logic [31:0] words);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_put(CFG_DATA_START, start);
    cfg_put(CFG_TOTAL, total);
    cfg_put(CFG_INIT_FREE, free_count);
    cfg_put(CFG_WORDS_USED, words);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [31:0] start;
    logic [31:0] total;
    logic [31:0] free_count;
    logic [10:0] words;
    logic [9:0]  idx;
    int unsigned s;
    int unsigned n;
    int unsigned pause_at;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: no free blocks straight after reset, extreme words and indexes
    apply_settings('0, '0, '0, '0);
    allocate_block();
    load_word('0, '1);
    load_word('1, '0);
    load_word(10'd1, ~(64'd1 << (WORD_BITS - 1)));
    load_word(10'd2, '0);
    allocate_block();

    // nothing searched, then only a full word searched
    apply_settings('0, '1, '1, '0);
    allocate_block();
    apply_settings('0, '1, '1, 32'd1);
    allocate_block();

    // top bit of a word taken, then the two searched words are full
    apply_settings('0, '1, '1, 32'd2);
    allocate_block();
    allocate_block();

    // block number carries past 32 bits, word count above the bitmap depth
    apply_settings('1, '1, 32'd3, 32'h7FF);
    allocate_block();

    // run up to the end of the disk
    apply_settings(32'd10, 32'd140, 32'd100, 32'd1024);
    allocate_block();
    allocate_block();
    allocate_block();

    // free count lowered below what has already been handed out
    apply_settings('0, '0, 32'd1, 32'd3);
    allocate_block();
    load_word(10'd1, '0);
    allocate_block();

    // random settings, each under one idling pattern
    for (s = 0; s < RANDOM_SETTINGS; s++) begin
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      case ($urandom_range(3))
        0: start = '0;
        1: start = 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
        2: start = $urandom_range(0, 5000);
        default: start = $urandom;
      endcase
      case ($urandom_range(4))
        1: total = start + $urandom_range(64, 4000);
        2: total = $urandom;
        3: total = start + $urandom_range(0, 40);
        default: total = '1;
      endcase
      case ($urandom_range(7))
        0: free_count = '0;
        1, 2: free_count = $urandom_range(1, 60);
        3: free_count = $urandom;
        default: free_count = '1;
      endcase
      case ($urandom_range(6))
        0: words = $urandom_range(1, 4);
        1: words = $urandom_range(5, 40);
        2: words = 11'd1024;
        3: words = $urandom_range(0, 2047);
        4: words = '0;
        default: words = $urandom_range(1, 8);
      endcase
      apply_settings(start, total, free_count, {21'($urandom), words});
      pause_at = $urandom_range(10, ITEMS_PER_SETTING - 10);
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        // hold the sender back until every result is in
        if (n == pause_at) begin
          wait_drained();
        end
        if ($urandom_range(99) < 55) begin
          allocate_block();
        end else begin
          idx = ($urandom_range(9) < 7) ? 10'($urandom_range(0, 15)) : 10'($urandom);
          load_word(idx, random_word());
        end
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("run covered %0d items under %0d register settings and four idling patterns",
             items_sent, settings_used);
    $display("results by status: ok %0d, no free %0d, beyond disk %0d, bitmap full %0d",
             status_hits[ST_OK], status_hits[ST_NO_FREE], status_hits[ST_BEYOND],
             status_hits[ST_FULL]);
    if (failures == 0 && pending == 0) begin
      $display("PASS bitmap_block_allocator");
    end else begin
      if (pending != 0) begin
        $error("%0d result items never arrived", pending);
      end
      $display("FAIL bitmap_block_allocator");
    end
    $finish;
  end

endmodule
